/* rtl/scev_pkg.sv */
`timescale 1ns / 1ps
package scev_pkg;

    // Internal values are signed Q7.56 in 64 bits.
    localparam int FRAC_BITS = 56;
    localparam int QMUL_LAT  = 4;

    localparam logic signed [32:0] PI_Q28     = 33'sd843314857;
    localparam logic signed [32:0] TWO_PI_Q28 = 33'sd1686629713;

    typedef logic signed [63:0] q56_t;

    // Running series state carried from one term to the next.
    typedef struct packed {
        q56_t x2;
        q56_t st;
        q56_t ss;
        q56_t ct;
        q56_t cs;
    } chain_t;

endpackage

/* rtl/sine_cosine_evaluator_core.sv */
`timescale 1ns / 1ps
// Sine and cosine evaluator.
// The input channel (in_valid, in_ready, angle) takes one item per cycle: an
// angle in radians as signed Q3.28. The output channel (out_valid, out_ready,
// sine, cosine) returns one item for every input item, in order, both results
// as signed Q1.30 saturated to the format limits.
// Each series term costs two chained 64-bit fixed-point multipliers of four
// stages each plus one add stage; the default is eight terms. Range reduction
// and squaring take one stage each, and the output rounding stage is the
// register that out_valid rises with.
// Throughput is one item per cycle unless the receiver stalls the output.
// The whole pipeline advances together whenever the output register is empty
// or being taken. When the receiver holds out_ready low with an item waiting,
// every stage freezes, in_ready drops, and nothing is lost or repeated.
// Reset clears all valid bits, so the block comes up empty and ready.
module sine_cosine_evaluator_core #(
    parameter int SERIES_TERMS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] sine,
    output logic signed [31:0] cosine
);
    import scev_pkg::*;

    logic               en;
    logic signed [32:0] a_wide;
    logic signed [31:0] a_reg, a_next;
    logic               v0_reg, v1_reg;
    q56_t               x_reg, x2_reg;
    chain_t             chain [SERIES_TERMS+1];
    logic               chain_v [SERIES_TERMS+1];
    logic signed [31:0] sine_reg, sine_next, cosine_reg, cosine_next;
    logic               out_valid_reg;

    // Round Q7.56 to Q1.30 to nearest, then saturate.
    function automatic logic signed [31:0] to_q30(input q56_t s);
        logic signed [64:0] t;
        logic signed [38:0] r;
        t = {s[63], s} + 65'sd33554432;
        r = 39'(t >>> 26);
        if ((&r[38:31]) || !(|r[38:31]))
        begin
            to_q30 = r[31:0];
        end
        else
        begin
            to_q30 = r[38] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    endfunction

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // One step of 2*pi always suffices over the whole Q3.28 range.
    always_comb
    begin
        a_wide = {angle[31], angle};
        if (a_wide > PI_Q28)
        begin
            a_wide = a_wide - TWO_PI_Q28;
        end
        else if (a_wide < -PI_Q28)
        begin
            a_wide = a_wide + TWO_PI_Q28;
        end
        a_next = a_wide[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= a_next;
            x2_reg     <= a_reg * a_reg;
            x_reg      <= {{4{a_reg[31]}}, a_reg, 28'd0};
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= in_valid;
            v1_reg        <= v0_reg;
            out_valid_reg <= chain_v[SERIES_TERMS];
        end
    end

    // The squared angle is exact, so it comes from a plain 32-bit square.
    always_comb
    begin
        chain[0].x2 = x2_reg;
        chain[0].st = x_reg;
        chain[0].ss = x_reg;
        chain[0].ct = 64'sd1 <<< FRAC_BITS;
        chain[0].cs = 64'sd1 <<< FRAC_BITS;
        chain_v[0]  = v1_reg;
    end

    for (genvar i = 0; i < SERIES_TERMS; i++)
    begin : g_term
        scev_term #(.TERM_INDEX(i + 1)) u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .valid_in (chain_v[i]),
            .chain_in (chain[i]),
            .valid_out(chain_v[i+1]),
            .chain_out(chain[i+1])
        );
    end

    always_comb
    begin
        sine_next   = to_q30(chain[SERIES_TERMS].ss);
        cosine_next = to_q30(chain[SERIES_TERMS].cs);
    end

    assign out_valid = out_valid_reg;
    assign sine      = sine_reg;
    assign cosine    = cosine_reg;

    a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg |-> ($signed({a_reg[31], a_reg}) <= PI_Q28
                    && $signed({a_reg[31], a_reg}) >= -PI_Q28))
        else $error("reduced angle outside [-pi, pi]");

    a_square_positive: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> !x2_reg[63])
        else $error("squared angle negative");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(a_reg) && $stable(v0_reg) && $stable(x2_reg)))
        else $error("front stages moved during a stall");

endmodule

/* rtl/scev_qmul.sv */
`timescale 1ns / 1ps
module scev_qmul (
    input  logic          clk,
    input  logic          en,
    input  scev_pkg::q56_t a,
    input  scev_pkg::q56_t b,
    output scev_pkg::q56_t y
);
    import scev_pkg::*;

    localparam logic [127:0] ROUND = 128'd1 << (FRAC_BITS - 1);

    logic [63:0]  ua_reg, ub_reg, ua_next, ub_next;
    logic         neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [63:0]  ll_next, lh_next, hl_next, hh_next;
    logic [127:0] prod_reg, prod_next;
    logic [63:0]  mag;
    q56_t         y_reg, y_next;

    // Magnitudes of both operands.
    always_comb
    begin
        ua_next = a[63] ? (64'd0 - a) : a;
        ub_next = b[63] ? (64'd0 - b) : b;
    end

    // Four 32 by 32 partial products.
    always_comb
    begin
        ll_next = ua_reg[31:0]  * ub_reg[31:0];
        lh_next = ua_reg[31:0]  * ub_reg[63:32];
        hl_next = ua_reg[63:32] * ub_reg[31:0];
        hh_next = ua_reg[63:32] * ub_reg[63:32];
    end

    // Full product with the rounding half added.
    always_comb
    begin
        prod_next = {hh_reg, ll_reg} + {32'd0, lh_reg, 32'd0}
                  + {32'd0, hl_reg, 32'd0} + ROUND;
    end

    // Clamp the magnitude and restore the sign.
    always_comb
    begin
        if (|prod_reg[127:119])
        begin
            mag = 64'h7fff_ffff_ffff_ffff;
        end
        else
        begin
            mag = {1'b0, prod_reg[118:56]};
        end
        y_next = neg3_reg ? (64'd0 - mag) : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= ua_next;
            ub_reg   <= ub_next;
            neg1_reg <= a[63] ^ b[63];
            ll_reg   <= ll_next;
            lh_reg   <= lh_next;
            hl_reg   <= hl_next;
            hh_reg   <= hh_next;
            neg2_reg <= neg1_reg;
            prod_reg <= prod_next;
            neg3_reg <= neg2_reg;
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule

/* rtl/scev_term.sv */
`timescale 1ns / 1ps
module scev_term #(
    parameter int TERM_INDEX = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  scev_pkg::chain_t chain_in,
    output logic             valid_out,
    output scev_pkg::chain_t chain_out
);
    import scev_pkg::*;

    localparam logic [63:0] DS = 64'(2 * TERM_INDEX * (2 * TERM_INDEX + 1));
    localparam logic [63:0] DC = 64'((2 * TERM_INDEX - 1) * (2 * TERM_INDEX));
    localparam logic [63:0] RS = ((64'd1 << FRAC_BITS) + DS / 2) / DS;
    localparam logic [63:0] RC = ((64'd1 << FRAC_BITS) + DC / 2) / DC;

    chain_t a_reg [QMUL_LAT];
    logic   va_reg [QMUL_LAT];
    chain_t b_reg [QMUL_LAT];
    logic   vb_reg [QMUL_LAT];
    chain_t out_reg, out_next;
    logic   vout_reg;
    q56_t   cfs, cfc, ps, pc;

    // Coefficients x^2 / d for this term.
    scev_qmul u_cfs (.clk(clk), .en(en), .a(chain_in.x2), .b(RS), .y(cfs));
    scev_qmul u_cfc (.clk(clk), .en(en), .a(chain_in.x2), .b(RC), .y(cfc));

    // Previous term times its coefficient.
    scev_qmul u_ps (.clk(clk), .en(en), .a(a_reg[QMUL_LAT-1].st), .b(cfs), .y(ps));
    scev_qmul u_pc (.clk(clk), .en(en), .a(a_reg[QMUL_LAT-1].ct), .b(cfc), .y(pc));

    always_comb
    begin
        out_next    = b_reg[QMUL_LAT-1];
        out_next.st = 64'sd0 - ps;
        out_next.ss = b_reg[QMUL_LAT-1].ss - ps;
        out_next.ct = 64'sd0 - pc;
        out_next.cs = b_reg[QMUL_LAT-1].cs - pc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= chain_in;
            b_reg[0] <= a_reg[QMUL_LAT-1];
            for (int k = 1; k < QMUL_LAT; k++)
            begin
                a_reg[k] <= a_reg[k-1];
                b_reg[k] <= b_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QMUL_LAT; k++)
            begin
                va_reg[k] <= 1'b0;
                vb_reg[k] <= 1'b0;
            end
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg[0] <= valid_in;
            vb_reg[0] <= va_reg[QMUL_LAT-1];
            for (int k = 1; k < QMUL_LAT; k++)
            begin
                va_reg[k] <= va_reg[k-1];
                vb_reg[k] <= vb_reg[k-1];
            end
            vout_reg <= vb_reg[QMUL_LAT-1];
        end
    end

    assign valid_out = vout_reg;
    assign chain_out = out_reg;

endmodule

/* bench/sine_cosine_evaluator_core_tb.sv */
`timescale 1ns / 1ps
module sine_cosine_evaluator_core_tb;

    localparam int TERMS       = 8;
    localparam int LATENCY     = 9 * TERMS + 2;
    localparam int RANDOM_ANGLES = 1950;
    localparam int IDLE_LIMIT  = 20000;
    localparam logic signed [63:0] PI_Q28_64     = 64'sd843314857;
    localparam logic signed [63:0] TWO_PI_Q28_64 = 64'sd1686629713;

    // Multiplies two Q7.56 values, rounding to nearest with ties away from zero.
    // The magnitude is clamped to the largest positive 64-bit value.
    function automatic logic signed [63:0] q56_mul(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic        neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [127:0] prod;
        logic [127:0] rounded;
        logic [63:0] mag;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        prod = ua * ub;
        rounded = prod + (128'd1 << 55);
        if ((rounded >> 56) > 128'h7FFF_FFFF_FFFF_FFFF)
            mag = 64'h7FFF_FFFF_FFFF_FFFF;
        else
            mag = rounded[119:56];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // Rounded reciprocal of an integer divisor in Q.56.
    function automatic logic signed [63:0] q56_recip(longint unsigned d);
        longint unsigned one;
        one = 64'd1 << 56;
        return $signed((one + d / 2) / d);
    endfunction

    // Rounds a Q7.56 sum to Q1.30 and saturates it to 32 bits.
    function automatic logic signed [31:0] q56_to_q30(logic signed [63:0] s);
        logic signed [65:0] r;
        r = ($signed({{2{s[63]}}, s}) + 66'sd33554432) >>> 26;
        if (r > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (r < -66'sd2147483648)
            return 32'sh8000_0000;
        return r[31:0];
    endfunction

    // Computes the expected sine and cosine of one Q3.28 angle.
    function automatic logic [63:0] sincos_of(logic signed [31:0] ang);
        logic signed [63:0] a;
        logic signed [63:0] x;
        logic signed [63:0] x2;
        logic signed [63:0] st;
        logic signed [63:0] ss;
        logic signed [63:0] ct;
        logic signed [63:0] cs;
        longint unsigned    k;
        a = ang;
        // Bring the angle into [-pi, pi]; one step covers the whole range.
        if (a > PI_Q28_64)
            a = a - TWO_PI_Q28_64;
        else if (a < -PI_Q28_64)
            a = a + TWO_PI_Q28_64;
        x = a <<< 28;
        x2 = q56_mul(x, x);
        st = x;
        ss = x;
        ct = 64'sd1 <<< 56;
        cs = ct;
        for (int i = 1; i <= TERMS; i++)
        begin
            k = i;
            st = -q56_mul(st, q56_mul(x2, q56_recip((2 * k) * (2 * k + 1))));
            ss = ss + st;
            ct = -q56_mul(ct, q56_mul(x2, q56_recip((2 * k - 1) * (2 * k))));
            cs = cs + ct;
        end
        return {q56_to_q30(ss), q56_to_q30(cs)};
    endfunction

    // Holds the expected results of accepted angles in order and checks the
    // block's results against them.
    class sincos_scoreboard;
        logic [63:0] pending[$];
        logic [31:0] angles[$];
        int          accepted;
        int          mismatches;
        int          unexpected;

        function void note_angle(logic signed [31:0] ang);
            pending.push_back(sincos_of(ang));
            angles.push_back(ang);
            accepted++;
        endfunction

        function void check_result(logic signed [31:0] s, logic signed [31:0] c);
            logic [63:0] exp_pair;
            logic [31:0] ang;
            if (pending.size() == 0)
            begin
                unexpected++;
                $display("Result with nothing pending: sine %h cosine %h", s, c);
                return;
            end
            exp_pair = pending.pop_front();
            ang = angles.pop_front();
            if (exp_pair[63:32] !== s || exp_pair[31:0] !== c)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch angle %h: sine %h expected %h, cosine %h expected %h",
                             ang, s, exp_pair[63:32], c, exp_pair[31:0]);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] angle;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] sine;
    logic signed [31:0] cosine;

    sincos_scoreboard board;
    int  idle_cycles;
    bit  long_hold;
    bit  hold_done;

    sine_cosine_evaluator_core #(.SERIES_TERMS(TERMS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sine      (sine),
        .cosine    (cosine)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Offers one angle and waits for it to be accepted. The scoreboard notes
    // the item at the accepting edge, so the expectation is queued in order.
    task automatic send_angle(logic signed [31:0] value);
        in_valid <= 1'b1;
        angle    <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_angle(value);
    endtask

    task automatic go_idle(int cycles);
        in_valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Waits until every expected result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Random angles favor the useful range around zero and the reduction
    // thresholds, with the remainder spread over the whole Q3.28 span.
    function automatic logic signed [31:0] random_angle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom;
        if (pick < 7)
            return $signed($urandom_range(0, 1686629713)) - 32'sd843314857;
        if (pick < 8)
            return 32'sd843314857 + $signed($urandom_range(0, 8)) - 32'sd4;
        if (pick < 9)
            return -32'sd843314857 + $signed($urandom_range(0, 8)) - 32'sd4;
        return $signed($urandom_range(0, 64)) - 32'sd32;
    endfunction

    // Results are checked at the edge where valid and ready are both high.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(sine, cosine);
    end

    // The receiver stalls on its own pattern. Once, it holds off for a long
    // stretch so the pipeline fills and the input stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (long_hold)
            out_ready <= 1'b0;
        else
        begin
            case ($urandom_range(0, 3))
                0: out_ready <= ($urandom_range(0, 3) != 0);
                1: out_ready <= 1'b1;
                2: out_ready <= ($urandom_range(0, 1) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin
        long_hold = 1'b0;
        hold_done = 1'b0;
        wait (board != null && board.accepted > 600);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (3 * LATENCY)
            @(posedge clk);
        long_hold <= 1'b0;
        hold_done = 1'b1;
    end

    // The watchdog counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("sine_cosine_evaluator_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int sent;
        int burst;
        logic signed [31:0] directed[$];
        board = new();
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        angle = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, zero, one LSB either side, the bounds at plus and minus pi and
        // their neighbors, plus and minus pi/2, 1.0 and 2*pi, and alternating bit patterns.
        directed = '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001,
                     32'shFFFF_FFFF, 32'sd843314857, 32'sd843314858, 32'sd843314856,
                     -32'sd843314857, -32'sd843314858, -32'sd843314856,
                     32'sd421657428, -32'sd421657428, 32'sd268435456,
                     -32'sd268435456, 32'sd1686629713, -32'sd1686629713,
                     32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1000_0000, 32'shF000_0000};
        foreach (directed[i])
            send_angle(directed[i]);

        // The sender pauses here until every expected result has come.
        drain();

        sent = 0;
        while (sent < RANDOM_ANGLES)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < RANDOM_ANGLES)
            begin
                send_angle(random_angle());
                sent++;
                burst--;
            end
            if ($urandom_range(0, 2) != 0)
                go_idle($urandom_range(1, 12));
        end

        drain();
        wait (hold_done);
        repeat (LATENCY + 10)
            @(posedge clk);

        if (board.mismatches == 0 && board.unexpected == 0 && board.pending.size() == 0)
            $display("sine_cosine_evaluator_core regression: pass");
        else
            $display("sine_cosine_evaluator_core regression: fail");
        $finish;
    end

endmodule
